@@ rtl/napar_pkg.sv @@
// Shared types and constants for the notification attribute parser.
`default_nettype none

package napar_pkg;

  localparam int unsigned CfgIndexWidth = 8;
  localparam int unsigned CfgDataWidth  = 10;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_APPID_CAP   = 8'd0,
    CFG_TITLE_CAP   = 8'd1,
    CFG_MESSAGE_CAP = 8'd2,
    CFG_DATE_CAP    = 8'd3
  } napar_cfg_idx_e;

  localparam logic [7:0] AppidCapReset   = 8'd32;
  localparam logic [7:0] TitleCapReset   = 8'd43;
  localparam logic [9:0] MessageCapReset = 10'd250;
  localparam logic [7:0] DateCapReset    = 8'd16;

  localparam logic [7:0] ATTR_APPID    = 8'd0;
  localparam logic [7:0] ATTR_TITLE    = 8'd1;
  localparam logic [7:0] ATTR_SUBTITLE = 8'd2;
  localparam logic [7:0] ATTR_MESSAGE  = 8'd3;
  localparam logic [7:0] ATTR_DATE     = 8'd5;

  localparam logic [2:0] UidLastCount = 3'd4;

  typedef enum logic [2:0] {
    PH_CMD     = 3'd0,
    PH_UID     = 3'd1,
    PH_ID      = 3'd2,
    PH_LEN_LO  = 3'd3,
    PH_LEN_HI  = 3'd4,
    PH_CONTENT = 3'd5,
    PH_DONE    = 3'd6
  } napar_phase_e;

  typedef enum logic [1:0] {
    KIND_HEADER     = 2'd0,
    KIND_KEPT       = 2'd1,
    KIND_DROPPED    = 2'd2,
    KIND_UNEXPECTED = 2'd3
  } napar_kind_e;

  typedef struct packed {
    logic [7:0] appid;
    logic [7:0] title;
    logic [9:0] message;
    logic [7:0] date;
  } napar_caps_t;

  typedef struct packed {
    napar_phase_e phase;
    logic [2:0]   header_count;
    logic [7:0]   current_attr;
    logic [7:0]   length_low_byte;
    logic [15:0]  bytes_remaining;
    logic [15:0]  write_offset;
  } napar_state_t;

  typedef struct packed {
    napar_kind_e kind;
    logic [7:0]  attr_code;
    logic [15:0] content_offset;
    logic [7:0]  content_byte;
    logic        attr_last;
    logic        notification_done;
  } napar_res_t;

  localparam napar_state_t StateIdle = '{
    phase:           PH_CMD,
    header_count:    3'd0,
    current_attr:    8'd0,
    length_low_byte: 8'd0,
    bytes_remaining: 16'd0,
    write_offset:    16'd0
  };

endpackage

`default_nettype wire

@@ rtl/napar_ifs.sv @@
// Channel interfaces: input byte, result word and configuration write.
`default_nettype none

interface napar_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       restart;
  logic       packet_last;

  modport source (output valid, output byte_value, output restart, output packet_last,
                  input ready);
  modport sink (input valid, input byte_value, input restart, input packet_last,
                output ready);
endinterface

interface napar_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  attr_code;
  logic [15:0] content_offset;
  logic [7:0]  content_byte;
  logic        attr_last;
  logic        notification_done;

  modport source (output valid, output kind, output attr_code, output content_offset,
                  output content_byte, output attr_last, output notification_done,
                  input ready);
  modport sink (input valid, input kind, input attr_code, input content_offset,
                input content_byte, input attr_last, input notification_done,
                output ready);
endinterface

interface napar_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [napar_pkg::CfgIndexWidth-1:0]   index;
  logic [napar_pkg::CfgDataWidth-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/napar_cfg_regs.sv @@
// Capacity registers behind the configuration write channel.
`default_nettype none

module napar_cfg_regs (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  napar_cfg_if.sink            cfg_i,
  output napar_pkg::napar_caps_t caps_o
);

  napar_pkg::napar_caps_t caps_q, caps_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    caps_d = caps_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        napar_pkg::CFG_APPID_CAP:   caps_d.appid   = cfg_i.data[7:0];
        napar_pkg::CFG_TITLE_CAP:   caps_d.title   = cfg_i.data[7:0];
        napar_pkg::CFG_MESSAGE_CAP: caps_d.message = cfg_i.data[9:0];
        napar_pkg::CFG_DATE_CAP:    caps_d.date    = cfg_i.data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      caps_q.appid   <= napar_pkg::AppidCapReset;
      caps_q.title   <= napar_pkg::TitleCapReset;
      caps_q.message <= napar_pkg::MessageCapReset;
      caps_q.date    <= napar_pkg::DateCapReset;
    end else begin
      caps_q <= caps_d;
    end
  end

  assign caps_o = caps_q;

endmodule

`default_nettype wire

@@ rtl/napar_step.sv @@
// Per-byte parse logic: next parser state and the result word for one byte.
`default_nettype none

module napar_step (
  input  napar_pkg::napar_state_t state_i,
  input  napar_pkg::napar_caps_t  caps_i,
  input  wire [7:0]               byte_value_i,
  input  wire                     restart_i,
  input  wire                     packet_last_i,
  output napar_pkg::napar_state_t state_o,
  output napar_pkg::napar_res_t   res_o
);

  napar_pkg::napar_state_t cur;
  napar_pkg::napar_state_t nxt;
  logic [15:0]             cap;
  logic                    cap_known;
  logic [15:0]             rem_dec;
  logic [2:0]              hc_inc;
  logic                    attr_done;

  always_comb begin
    cap       = 16'd0;
    cap_known = 1'b1;
    case (cur.current_attr)
      napar_pkg::ATTR_APPID:    cap = {8'd0, caps_i.appid};
      napar_pkg::ATTR_TITLE,
      napar_pkg::ATTR_SUBTITLE: cap = {8'd0, caps_i.title};
      napar_pkg::ATTR_MESSAGE:  cap = {6'd0, caps_i.message};
      napar_pkg::ATTR_DATE:     cap = {8'd0, caps_i.date};
      default:                  cap_known = 1'b0;
    endcase
  end

  always_comb begin
    cur       = restart_i ? napar_pkg::StateIdle : state_i;
    nxt       = cur;
    rem_dec   = cur.bytes_remaining - 16'd1;
    hc_inc    = cur.header_count + 3'd1;
    attr_done = 1'b0;

    res_o.kind              = napar_pkg::KIND_HEADER;
    res_o.attr_code         = 8'd0;
    res_o.content_offset    = 16'd0;
    res_o.content_byte      = byte_value_i;
    res_o.attr_last         = 1'b0;
    res_o.notification_done = 1'b0;

    case (cur.phase)
      napar_pkg::PH_UID: begin
        nxt.header_count = hc_inc;
        if (hc_inc >= napar_pkg::UidLastCount) begin
          nxt.phase = napar_pkg::PH_ID;
        end
      end
      napar_pkg::PH_ID: begin
        nxt.current_attr = byte_value_i;
        res_o.attr_code  = byte_value_i;
        nxt.phase        = napar_pkg::PH_LEN_LO;
      end
      napar_pkg::PH_LEN_LO: begin
        nxt.length_low_byte = byte_value_i;
        res_o.attr_code     = cur.current_attr;
        nxt.phase           = napar_pkg::PH_LEN_HI;
      end
      napar_pkg::PH_LEN_HI: begin
        res_o.attr_code     = cur.current_attr;
        nxt.bytes_remaining = {byte_value_i, cur.length_low_byte};
        nxt.write_offset    = 16'd0;
        if ({byte_value_i, cur.length_low_byte} == 16'd0) begin
          attr_done = 1'b1;
        end else begin
          nxt.phase = napar_pkg::PH_CONTENT;
        end
      end
      napar_pkg::PH_CONTENT: begin
        res_o.attr_code      = cur.current_attr;
        res_o.content_offset = cur.write_offset;
        res_o.kind           = (cap_known && (cur.write_offset < cap)) ?
                               napar_pkg::KIND_KEPT : napar_pkg::KIND_DROPPED;
        nxt.write_offset     = cur.write_offset + 16'd1;
        nxt.bytes_remaining  = rem_dec;
        attr_done            = (rem_dec == 16'd0);
      end
      napar_pkg::PH_DONE: begin
        res_o.kind = napar_pkg::KIND_UNEXPECTED;
      end
      default: begin
        nxt.header_count = 3'd0;
        nxt.phase        = napar_pkg::PH_UID;
      end
    endcase

    if (attr_done) begin
      res_o.attr_last = 1'b1;
      nxt.phase = (cur.current_attr == napar_pkg::ATTR_DATE) ?
                  napar_pkg::PH_DONE : napar_pkg::PH_ID;
    end

    if (packet_last_i && (nxt.phase == napar_pkg::PH_DONE)) begin
      res_o.notification_done = 1'b1;
      nxt = napar_pkg::StateIdle;
    end
  end

  assign state_o = nxt;

endmodule

`default_nettype wire

@@ rtl/notification_attribute_parser.sv @@
// Top level of the notification attribute parser.
// Takes one data-source byte per cycle unless the output stalls and returns
// one result word per byte. Each byte is parsed in the cycle it is accepted
// and its result word sits in the output register on the next cycle; a byte
// is accepted whenever that register is empty or is being drained in the
// same cycle, so the sustained rate is one byte per clock. Capacity registers
// are written through the configuration channel, which is always ready.
`default_nettype none

module notification_attribute_parser (
  input  wire          clk_i,
  input  wire          rst_ni,
  napar_cfg_if.sink    cfg_i,
  napar_in_if.sink     in_i,
  napar_res_if.source  res_o
);

  napar_pkg::napar_caps_t  caps;
  napar_pkg::napar_state_t state_q, state_d;
  napar_pkg::napar_res_t   res_q, res_d;
  logic                    res_valid_q;
  logic                    accept;

  napar_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .caps_o (caps)
  );

  napar_step u_step (
    .state_i       (state_q),
    .caps_i        (caps),
    .byte_value_i  (in_i.byte_value),
    .restart_i     (in_i.restart),
    .packet_last_i (in_i.packet_last),
    .state_o       (state_d),
    .res_o         (res_d)
  );

  assign in_i.ready = !res_valid_q || res_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= napar_pkg::StateIdle;
      res_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        state_q     <= state_d;
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid             = res_valid_q;
  assign res_o.kind              = res_q.kind;
  assign res_o.attr_code         = res_q.attr_code;
  assign res_o.content_offset    = res_q.content_offset;
  assign res_o.content_byte      = res_q.content_byte;
  assign res_o.attr_last         = res_q.attr_last;
  assign res_o.notification_done = res_q.notification_done;

endmodule

`default_nettype wire

@@ rtl/napar_checker.sv @@
// Port-level checks for the notification attribute parser, bound to the top.
`default_nettype none

module napar_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid,
  input wire        in_ready,
  input wire [7:0]  in_byte,
  input wire        res_valid,
  input wire        res_ready,
  input wire [1:0]  res_kind,
  input wire [7:0]  res_attr_code,
  input wire [15:0] res_offset,
  input wire [7:0]  res_byte,
  input wire        res_attr_last,
  input wire        res_done
);

  // a stalled result word holds
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(res_byte) && $stable(res_kind)
      && $stable(res_offset))
    else $error("result word changed while stalled");

  // each accepted byte shows up next cycle, echoed
  a_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> res_valid && (res_byte == $past(in_byte)))
    else $error("accepted byte not echoed on next cycle");

  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_done |->
      (res_attr_last && (res_attr_code == napar_pkg::ATTR_DATE))
      || (res_kind == napar_pkg::KIND_UNEXPECTED))
    else $error("notification done without date completion");

  a_unexpected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && (res_kind == napar_pkg::KIND_UNEXPECTED) |->
      (res_attr_code == 8'd0) && (res_offset == 16'd0) && !res_attr_last)
    else $error("unexpected byte carries attribute fields");

  a_header_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && (res_kind == napar_pkg::KIND_HEADER) |-> (res_offset == 16'd0))
    else $error("header byte with nonzero offset");

endmodule

bind notification_attribute_parser napar_checker u_napar_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid      (in_i.valid),
  .in_ready      (in_i.ready),
  .in_byte       (in_i.byte_value),
  .res_valid     (res_o.valid),
  .res_ready     (res_o.ready),
  .res_kind      (res_o.kind),
  .res_attr_code (res_o.attr_code),
  .res_offset    (res_o.content_offset),
  .res_byte      (res_o.content_byte),
  .res_attr_last (res_o.attr_last),
  .res_done      (res_o.notification_done)
);

`default_nettype wire
